/* src/assert_macros.svh */
// Assertion macros shared by the command stream parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, quiet while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

/* src/rcsp_pkg.sv */
// Package: shared types and codes of the register command stream parser.
`timescale 1ns / 1ps
package rcsp_pkg;

	// input op codes
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_PAUSE = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_END   = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_WRITE    = 3'd0;
	localparam logic [2:0] KIND_BURST    = 3'd1;
	localparam logic [2:0] KIND_WAIT     = 3'd2;
	localparam logic [2:0] KIND_HWRESET  = 3'd3;
	localparam logic [2:0] KIND_BAD_CMD  = 3'd4;
	localparam logic [2:0] KIND_BAD_ADDR = 3'd5;

	// command bytes
	localparam logic [7:0] CMD_NOOP    = 8'h00;
	localparam logic [7:0] CMD_FLUSH   = 8'h80;
	localparam logic [7:0] CMD_WRITE   = 8'h10;
	localparam logic [7:0] CMD_LIST8A  = 8'h12;
	localparam logic [7:0] CMD_LIST16A = 8'h13;
	localparam logic [7:0] CMD_LIST8B  = 8'h14;
	localparam logic [7:0] CMD_LIST16B = 8'h15;
	localparam logic [7:0] CMD_BURST8  = 8'h20;
	localparam logic [7:0] CMD_BURST16 = 8'h21;
	localparam logic [7:0] CMD_TARGET  = 8'h90;
	localparam logic [7:0] CMD_HWRESET = 8'he0;
	localparam logic [7:0] CMD_WAIT8A  = 8'hfc;
	localparam logic [7:0] CMD_WAIT16A = 8'hfd;
	localparam logic [7:0] CMD_WAIT8B  = 8'hfe;
	localparam logic [7:0] CMD_WAIT16B = 8'hff;

	// note-off run constants
	localparam logic [7:0] NOTE_OFF_TARGET = 8'd3;
	localparam logic [7:0] NOTE_OFF_ADDR_A = 8'h0b;
	localparam logic [7:0] NOTE_OFF_ADDR_B = 8'h0f;

	localparam logic [7:0] TARGET_RESET = 8'd3;

	// front to back queue
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// one queued job: either a single finished result or a note-off run
	typedef struct packed {
		logic        pause;
		logic [2:0]  kind;
		logic [7:0]  target;
		logic [7:0]  addr;
		logic [7:0]  data;
		logic [16:0] wait_ticks;
		logic        first;
	} job_t;

endpackage

/* src/register_command_stream_parser_top.sv */
// Top level of the register command stream parser.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_ready): one item per handshake. op selects a
//   command stream byte (stream_byte), a pause, a stop request or end of stream.
//   Output channel (out_valid / out_ready): one result per handshake - register
//   write, burst data byte, wait count, hardware reset or error. run_last marks
//   the last result caused by an input item; items that cause nothing are silent.
// Pipeline and throughput:
//   A taken item's result passes through the job queue and then the output
//   register. One item per cycle is sustained while the job queue has room;
//   each ordinary item makes at most one result, keeping pace with the source.
//   A pause expands into 2*NOTE_OFF_CHANNELS note-off writes, one per cycle from
//   the back end counter while out_ready is high; the two-entry job queue fills
//   and in_ready drops until the run drains. That counter sets the pause rate.
// Reset:
//   arst_n clears the parser to idle, target 3, not halted, and empties the
//   queue and output register. A stop item resets only the parser, in-band, and
//   emits one hardware reset result; after an error items are dropped until stop.
// Stalls:
//   With out_ready low the output register holds its result; the front end
//   keeps taking items until the job queue is full.
module register_command_stream_parser_top #(
	parameter int NOTE_OFF_CHANNELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  target,
	output logic [7:0]  reg_address,
	output logic [7:0]  reg_data,
	output logic [16:0] wait_ticks,
	output logic        burst_first,
	output logic        run_last
);

	logic           push;
	logic           q_full;
	logic           pop;
	logic           head_valid;
	rcsp_pkg::job_t push_job;
	rcsp_pkg::job_t head_job;

	// parse the byte stream and classify each item into a job
	rcsp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.stream_byte (stream_byte),
		.q_full      (q_full),
		.push        (push),
		.push_job    (push_job)
	);

	// decouple parser from result delivery
	rcsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// expand jobs into result items
	rcsp_back #(
		.NOTE_OFF_CHANNELS (NOTE_OFF_CHANNELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.target      (target),
		.reg_address (reg_address),
		.reg_data    (reg_data),
		.wait_ticks  (wait_ticks),
		.burst_first (burst_first),
		.run_last    (run_last)
	);

endmodule

/* src/rcsp_front.sv */
// Front end: accepts stream items, runs the command parser, emits jobs.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rcsp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      op,
	input  logic [7:0]      stream_byte,
	input  logic            q_full,
	output logic            push,
	output rcsp_pkg::job_t  push_job
);

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_W_ADDR  = 4'd1;
	localparam logic [3:0] PH_W_DATA  = 4'd2;
	localparam logic [3:0] PH_L_LO    = 4'd3;
	localparam logic [3:0] PH_L_HI    = 4'd4;
	localparam logic [3:0] PH_P_ADDR  = 4'd5;
	localparam logic [3:0] PH_P_DATA  = 4'd6;
	localparam logic [3:0] PH_B_ADDR  = 4'd7;
	localparam logic [3:0] PH_B_LO    = 4'd8;
	localparam logic [3:0] PH_B_HI    = 4'd9;
	localparam logic [3:0] PH_B_FIRST = 4'd10;
	localparam logic [3:0] PH_B_DATA  = 4'd11;
	localparam logic [3:0] PH_TARGET  = 4'd12;
	localparam logic [3:0] PH_WAIT_LO = 4'd13;
	localparam logic [3:0] PH_WAIT_HI = 4'd14;

	logic [3:0]  phase_q, phase_n;
	logic [7:0]  command_q, command_n;
	logic [7:0]  target_q, target_n;
	logic [7:0]  haddr_q, haddr_n;
	logic [7:0]  len_lo_q, len_lo_n;
	logic [15:0] rem_q, rem_n;
	logic        halted_q, halted_n;
	logic        accept;
	logic        emit;
	logic [15:0] rem_dec;
	logic [15:0] len16;
	rcsp_pkg::job_t job;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign rem_dec  = (rem_q != 16'd0) ? rem_q - 16'd1 : 16'd0;
	assign len16    = {stream_byte, len_lo_q};

	always_comb begin
		phase_n   = phase_q;
		command_n = command_q;
		target_n  = target_q;
		haddr_n   = haddr_q;
		len_lo_n  = len_lo_q;
		rem_n     = rem_q;
		halted_n  = halted_q;
		emit      = 1'b0;
		job       = '0;
		if (op == rcsp_pkg::OP_STOP) begin
			phase_n   = PH_IDLE;
			command_n = 8'd0;
			target_n  = rcsp_pkg::TARGET_RESET;
			haddr_n   = 8'd0;
			len_lo_n  = 8'd0;
			rem_n     = 16'd0;
			halted_n  = 1'b0;
			emit      = 1'b1;
			job.kind  = rcsp_pkg::KIND_HWRESET;
		end else if (halted_q) begin
			// drop everything until stop
		end else if (op == rcsp_pkg::OP_END) begin
			phase_n   = PH_IDLE;
			command_n = 8'd0;
			target_n  = rcsp_pkg::TARGET_RESET;
			haddr_n   = 8'd0;
			len_lo_n  = 8'd0;
			rem_n     = 16'd0;
		end else if (op == rcsp_pkg::OP_PAUSE) begin
			emit      = 1'b1;
			job.pause = 1'b1;
		end else begin
			unique case (phase_q) inside
				PH_IDLE: begin
					command_n = stream_byte;
					unique case (stream_byte) inside
						rcsp_pkg::CMD_NOOP, rcsp_pkg::CMD_FLUSH: begin
						end
						rcsp_pkg::CMD_WRITE: begin
							phase_n = PH_W_ADDR;
						end
						rcsp_pkg::CMD_LIST8A, rcsp_pkg::CMD_LIST16A,
						rcsp_pkg::CMD_LIST8B, rcsp_pkg::CMD_LIST16B: begin
							phase_n = PH_L_LO;
						end
						rcsp_pkg::CMD_BURST8, rcsp_pkg::CMD_BURST16: begin
							phase_n = PH_B_ADDR;
						end
						rcsp_pkg::CMD_TARGET: begin
							phase_n = PH_TARGET;
						end
						rcsp_pkg::CMD_HWRESET: begin
							emit     = 1'b1;
							job.kind = rcsp_pkg::KIND_HWRESET;
						end
						rcsp_pkg::CMD_WAIT8A, rcsp_pkg::CMD_WAIT16A,
						rcsp_pkg::CMD_WAIT8B, rcsp_pkg::CMD_WAIT16B: begin
							phase_n = PH_WAIT_LO;
						end
						default: begin
							emit       = 1'b1;
							job.kind   = rcsp_pkg::KIND_BAD_CMD;
							job.target = target_q;
							job.data   = stream_byte;
							halted_n   = 1'b1;
						end
					endcase
				end
				PH_W_ADDR, PH_B_ADDR: begin
					if (stream_byte[7]) begin
						emit       = 1'b1;
						job.kind   = rcsp_pkg::KIND_BAD_ADDR;
						job.target = target_q;
						job.addr   = stream_byte;
						job.data   = command_q;
						halted_n   = 1'b1;
						phase_n    = PH_IDLE;
					end else begin
						haddr_n = stream_byte;
						phase_n = (phase_q == PH_W_ADDR) ? PH_W_DATA : PH_B_LO;
					end
				end
				PH_W_DATA: begin
					emit       = 1'b1;
					job.kind   = rcsp_pkg::KIND_WRITE;
					job.target = target_q;
					job.addr   = haddr_q;
					job.data   = stream_byte;
					phase_n    = PH_IDLE;
				end
				PH_L_LO: begin
					if (!command_q[0]) begin
						rem_n   = {8'd0, stream_byte};
						phase_n = (stream_byte != 8'd0) ? PH_P_ADDR : PH_IDLE;
					end else begin
						len_lo_n = stream_byte;
						phase_n  = PH_L_HI;
					end
				end
				PH_L_HI: begin
					rem_n   = len16;
					phase_n = (len16 != 16'd0) ? PH_P_ADDR : PH_IDLE;
				end
				PH_P_ADDR: begin
					haddr_n = stream_byte;
					phase_n = PH_P_DATA;
				end
				PH_P_DATA: begin
					emit       = 1'b1;
					job.kind   = rcsp_pkg::KIND_WRITE;
					job.target = target_q;
					job.addr   = haddr_q;
					job.data   = stream_byte;
					rem_n      = rem_dec;
					phase_n    = (rem_dec != 16'd0) ? PH_P_ADDR : PH_IDLE;
				end
				PH_B_LO: begin
					if (command_q == rcsp_pkg::CMD_BURST8) begin
						rem_n   = {8'd0, stream_byte};
						phase_n = (stream_byte != 8'd0) ? PH_B_FIRST : PH_IDLE;
					end else begin
						len_lo_n = stream_byte;
						phase_n  = PH_B_HI;
					end
				end
				PH_B_HI: begin
					rem_n   = len16;
					phase_n = (len16 != 16'd0) ? PH_B_FIRST : PH_IDLE;
				end
				PH_B_FIRST, PH_B_DATA: begin
					emit       = 1'b1;
					job.kind   = rcsp_pkg::KIND_BURST;
					job.target = target_q;
					job.addr   = haddr_q;
					job.data   = stream_byte;
					job.first  = (phase_q == PH_B_FIRST);
					rem_n      = rem_dec;
					phase_n    = (rem_dec != 16'd0) ? PH_B_DATA : PH_IDLE;
				end
				PH_TARGET: begin
					target_n = stream_byte;
					phase_n  = PH_IDLE;
				end
				PH_WAIT_LO: begin
					if (!command_q[0]) begin
						emit           = 1'b1;
						job.kind       = rcsp_pkg::KIND_WAIT;
						job.wait_ticks = {9'd0, stream_byte} + 17'd1;
						phase_n        = PH_IDLE;
					end else begin
						len_lo_n = stream_byte;
						phase_n  = PH_WAIT_HI;
					end
				end
				PH_WAIT_HI: begin
					emit           = 1'b1;
					job.kind       = rcsp_pkg::KIND_WAIT;
					job.wait_ticks = {1'b0, len16} + 17'd1;
					phase_n        = PH_IDLE;
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end
	end

	assign push     = accept && emit;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			command_q <= 8'd0;
			target_q  <= rcsp_pkg::TARGET_RESET;
			haddr_q   <= 8'd0;
			len_lo_q  <= 8'd0;
			rem_q     <= 16'd0;
			halted_q  <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_n;
			command_q <= command_n;
			target_q  <= target_n;
			haddr_q   <= haddr_n;
			len_lo_q  <= len_lo_n;
			rem_q     <= rem_n;
			halted_q  <= halted_n;
		end
	end

	// an error always drops the parser back to idle before it halts
	`ASSERT_IMPLY(a_halt_idle, halted_q, phase_q == PH_IDLE, "halted outside idle phase")

endmodule

/* src/rcsp_queue.sv */
// Short job queue between the parser front end and the result back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rcsp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rcsp_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output rcsp_pkg::job_t  head_job
);

	rcsp_pkg::job_t                 slot_q [rcsp_pkg::Q_DEPTH];
	logic [rcsp_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [rcsp_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [rcsp_pkg::Q_CNT_W-1:0]   cnt_q;

	localparam logic [rcsp_pkg::Q_PTR_W-1:0] PTR_LAST =
		rcsp_pkg::Q_PTR_W'(rcsp_pkg::Q_DEPTH - 1);
	localparam logic [rcsp_pkg::Q_CNT_W-1:0] CNT_FULL =
		rcsp_pkg::Q_CNT_W'(rcsp_pkg::Q_DEPTH);

	assign full       = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_CLK(a_q_bound, cnt_q <= CNT_FULL, "queue count beyond depth")
	`ASSERT_IMPLY(a_q_pop, pop, cnt_q != '0, "pop from empty queue")

endmodule

/* src/rcsp_back.sv */
// Back end: expands queued jobs into result items behind an output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rcsp_back #(
	parameter int NOTE_OFF_CHANNELS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  rcsp_pkg::job_t  head_job,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      kind,
	output logic [7:0]      target,
	output logic [7:0]      reg_address,
	output logic [7:0]      reg_data,
	output logic [16:0]     wait_ticks,
	output logic            burst_first,
	output logic            run_last
);

	localparam int RUN_LEN = 2 * NOTE_OFF_CHANNELS;
	localparam int CNT_W   = $clog2(RUN_LEN);
	localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(RUN_LEN - 1);

	logic             valid_q;
	logic [2:0]       kind_q;
	logic [7:0]       target_q;
	logic [7:0]       addr_q;
	logic [7:0]       data_q;
	logic [16:0]      wait_q;
	logic             first_q;
	logic             last_q;
	logic             run_q;
	logic [CNT_W-1:0] cnt_q;

	logic             out_free;
	logic [CNT_W-1:0] idx;
	logic             use_note;

	assign out_free = !valid_q || out_ready;
	assign pop      = out_free && !run_q && head_valid;
	assign use_note = run_q || head_job.pause;
	assign idx      = run_q ? cnt_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			run_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (out_free) begin
			valid_q <= run_q || head_valid;
			if (run_q) begin
				if (cnt_q == IDX_LAST) begin
					run_q <= 1'b0;
					cnt_q <= '0;
				end else begin
					cnt_q <= CNT_W'(cnt_q + 1'b1);
				end
			end else if (head_valid && head_job.pause) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && (run_q || head_valid)) begin
			if (use_note) begin
				kind_q   <= rcsp_pkg::KIND_WRITE;
				target_q <= rcsp_pkg::NOTE_OFF_TARGET;
				addr_q   <= idx[0] ? rcsp_pkg::NOTE_OFF_ADDR_B : rcsp_pkg::NOTE_OFF_ADDR_A;
				data_q   <= 8'(idx >> 1);
				wait_q   <= 17'd0;
				first_q  <= 1'b0;
				last_q   <= (idx == IDX_LAST);
			end else begin
				kind_q   <= head_job.kind;
				target_q <= head_job.target;
				addr_q   <= head_job.addr;
				data_q   <= head_job.data;
				wait_q   <= head_job.wait_ticks;
				first_q  <= head_job.first;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid   = valid_q;
	assign kind        = kind_q;
	assign target      = target_q;
	assign reg_address = addr_q;
	assign reg_data    = data_q;
	assign wait_ticks  = wait_q;
	assign burst_first = first_q;
	assign run_last    = last_q;

	`ASSERT_IMPLY(a_run_shown, run_q, valid_q, "note-off run without a shown result")
	`ASSERT_IMPLY(a_run_cnt, run_q, cnt_q != '0, "note-off run index lost its first step")

endmodule

/* bench/testbench.sv */
// Testbench for the command stream parser: directed table, random streams, scoreboard.
`timescale 1ns / 1ps
module testbench;

	localparam int NOTE_OFF_CHANNELS = 16;
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 5;
	localparam int TOTAL_ITEMS = 280;
	localparam int QUIET_TAIL = 30;      // last items run with no idling on either side
	localparam int LONG_HOLD_AT = 60;    // items taken before the long receiver hold-off
	localparam int LONG_HOLD = 150;
	localparam int DRAIN_CYCLES = 12;
	localparam int LIMIT_CYCLES = 400000;
	localparam int REPORT_MAX = 10;

	// parser phase codes of the predictor
	localparam logic [3:0] P_IDLE        = 4'd0;
	localparam logic [3:0] P_WR_ADDR     = 4'd1;
	localparam logic [3:0] P_WR_DATA     = 4'd2;
	localparam logic [3:0] P_LIST_LO     = 4'd3;
	localparam logic [3:0] P_LIST_HI     = 4'd4;
	localparam logic [3:0] P_PAIR_ADDR   = 4'd5;
	localparam logic [3:0] P_PAIR_DATA   = 4'd6;
	localparam logic [3:0] P_BURST_ADDR  = 4'd7;
	localparam logic [3:0] P_BURST_LO    = 4'd8;
	localparam logic [3:0] P_BURST_HI    = 4'd9;
	localparam logic [3:0] P_BURST_FIRST = 4'd10;
	localparam logic [3:0] P_BURST_DATA  = 4'd11;
	localparam logic [3:0] P_TARGET      = 4'd12;
	localparam logic [3:0] P_WAIT_LO     = 4'd13;
	localparam logic [3:0] P_WAIT_HI     = 4'd14;

	// one decoded result as it leaves the block
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  target;
		logic [7:0]  addr;
		logic [7:0]  data;
		logic [16:0] ticks;
		logic        is_first;
		logic        is_last;
	} result_t;

	// one input item; rows of the directed table may carry their expected result
	typedef struct {
		logic [1:0] op;
		logic [7:0] b;
		bit         typed;
		bit         has_res;
		result_t    res;
	} stim_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  stream_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [7:0]  target;
	logic [7:0]  reg_address;
	logic [7:0]  reg_data;
	logic [16:0] wait_ticks;
	logic        burst_first;
	logic        run_last;

	stim_t   stim_q[$];
	result_t decoded_q[$];          // results of the item being decoded
	result_t expected_results[$];   // results still owed by the block

	// parser state mirror
	logic [3:0]   ph;
	logic [7:0]   cur_cmd;
	logic [7:0]   cur_target;
	logic [7:0]   held_addr;
	logic [7:0]   len_lo;
	logic [16:0]  remain;
	logic         halted;

	int  offer_idx;
	int  items_taken = 0;
	int  pause_items = 0;
	int  results_seen = 0;
	int  error_results = 0;
	int  failures = 0;
	int  cycle_count = 0;
	bit  sender_done = 1'b0;

	register_command_stream_parser_top #(.NOTE_OFF_CHANNELS(NOTE_OFF_CHANNELS)) dut (.*);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	function automatic result_t make_result(logic [2:0] k, logic [7:0] t, logic [7:0] a,
			logic [7:0] d, logic [16:0] w, logic f);
		result_t r;
		r.kind = k;
		r.target = t;
		r.addr = a;
		r.data = d;
		r.ticks = w;
		r.is_first = f;
		r.is_last = 1'b0;
		return r;
	endfunction

	function automatic void emit(logic [2:0] k, logic [7:0] t, logic [7:0] a, logic [7:0] d,
			logic [16:0] w, logic f);
		decoded_q.push_back(make_result(k, t, a, d, w, f));
	endfunction

	// drop any partly parsed command; halted is left alone
	function automatic void clear_parser();
		ph = P_IDLE;
		cur_cmd = rcsp_pkg::CMD_NOOP;
		cur_target = rcsp_pkg::TARGET_RESET;
		held_addr = '0;
		len_lo = '0;
		remain = '0;
	endfunction

	function automatic void begin_run(logic [16:0] n, bit burst);
		remain = n;
		if (n == 0)
			ph = P_IDLE;
		else
			ph = burst ? P_BURST_FIRST : P_PAIR_ADDR;
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		unique case (ph) inside
			P_IDLE: begin
				cur_cmd = b;
				unique case (b) inside
					rcsp_pkg::CMD_NOOP, rcsp_pkg::CMD_FLUSH: ;
					rcsp_pkg::CMD_WRITE: ph = P_WR_ADDR;
					rcsp_pkg::CMD_LIST8A, rcsp_pkg::CMD_LIST16A,
					rcsp_pkg::CMD_LIST8B, rcsp_pkg::CMD_LIST16B: ph = P_LIST_LO;
					rcsp_pkg::CMD_BURST8, rcsp_pkg::CMD_BURST16: ph = P_BURST_ADDR;
					rcsp_pkg::CMD_TARGET: ph = P_TARGET;
					rcsp_pkg::CMD_HWRESET: emit(rcsp_pkg::KIND_HWRESET, '0, '0, '0, '0, 1'b0);
					rcsp_pkg::CMD_WAIT8A, rcsp_pkg::CMD_WAIT16A,
					rcsp_pkg::CMD_WAIT8B, rcsp_pkg::CMD_WAIT16B: ph = P_WAIT_LO;
					default: begin
						emit(rcsp_pkg::KIND_BAD_CMD, cur_target, '0, b, '0, 1'b0);
						halted = 1'b1;
					end
				endcase
			end
			P_WR_ADDR, P_BURST_ADDR: begin
				// address is checked as soon as it arrives
				if (b[7]) begin
					emit(rcsp_pkg::KIND_BAD_ADDR, cur_target, b, cur_cmd, '0, 1'b0);
					halted = 1'b1;
					ph = P_IDLE;
				end else begin
					held_addr = b;
					ph = (ph == P_WR_ADDR) ? P_WR_DATA : P_BURST_LO;
				end
			end
			P_WR_DATA: begin
				emit(rcsp_pkg::KIND_WRITE, cur_target, held_addr, b, '0, 1'b0);
				ph = P_IDLE;
			end
			P_LIST_LO: begin
				if (!cur_cmd[0]) begin
					begin_run({9'd0, b}, 1'b0);
				end else begin
					len_lo = b;
					ph = P_LIST_HI;
				end
			end
			P_LIST_HI: begin_run({1'b0, b, len_lo}, 1'b0);
			P_PAIR_ADDR: begin
				held_addr = b;
				ph = P_PAIR_DATA;
			end
			P_PAIR_DATA: begin
				emit(rcsp_pkg::KIND_WRITE, cur_target, held_addr, b, '0, 1'b0);
				remain = remain - 1'b1;
				ph = (remain != 0) ? P_PAIR_ADDR : P_IDLE;
			end
			P_BURST_LO: begin
				if (cur_cmd == rcsp_pkg::CMD_BURST8) begin
					begin_run({9'd0, b}, 1'b1);
				end else begin
					len_lo = b;
					ph = P_BURST_HI;
				end
			end
			P_BURST_HI: begin_run({1'b0, b, len_lo}, 1'b1);
			P_BURST_FIRST, P_BURST_DATA: begin
				emit(rcsp_pkg::KIND_BURST, cur_target, held_addr, b, '0, ph == P_BURST_FIRST);
				remain = remain - 1'b1;
				ph = (remain != 0) ? P_BURST_DATA : P_IDLE;
			end
			P_TARGET: begin
				cur_target = b;
				ph = P_IDLE;
			end
			P_WAIT_LO: begin
				if (!cur_cmd[0]) begin
					emit(rcsp_pkg::KIND_WAIT, '0, '0, '0, {9'd0, b} + 17'd1, 1'b0);
					ph = P_IDLE;
				end else begin
					len_lo = b;
					ph = P_WAIT_HI;
				end
			end
			P_WAIT_HI: begin
				emit(rcsp_pkg::KIND_WAIT, '0, '0, '0, {1'b0, b, len_lo} + 17'd1, 1'b0);
				ph = P_IDLE;
			end
			default: ph = P_IDLE;
		endcase
	endfunction

	// work out every result one accepted item causes, into decoded_q
	function automatic void decode_item(logic [1:0] o, logic [7:0] b);
		decoded_q.delete();
		if (o == rcsp_pkg::OP_STOP) begin
			clear_parser();
			halted = 1'b0;
			emit(rcsp_pkg::KIND_HWRESET, '0, '0, '0, '0, 1'b0);
		end else if (halted) begin
			// dropped until stop
		end else if (o == rcsp_pkg::OP_END) begin
			clear_parser();
		end else if (o == rcsp_pkg::OP_PAUSE) begin
			for (int ch = 0; ch < NOTE_OFF_CHANNELS; ch++) begin
				emit(rcsp_pkg::KIND_WRITE, rcsp_pkg::NOTE_OFF_TARGET, rcsp_pkg::NOTE_OFF_ADDR_A,
					8'(ch), '0, 1'b0);
				emit(rcsp_pkg::KIND_WRITE, rcsp_pkg::NOTE_OFF_TARGET, rcsp_pkg::NOTE_OFF_ADDR_B,
					8'(ch), '0, 1'b0);
			end
		end else begin
			decode_byte(b);
		end
		if (decoded_q.size() > 0)
			decoded_q[decoded_q.size() - 1].is_last = 1'b1;
	endfunction

	function automatic bit is_command(logic [7:0] b);
		case (b) inside
			rcsp_pkg::CMD_NOOP, rcsp_pkg::CMD_FLUSH, rcsp_pkg::CMD_WRITE,
			rcsp_pkg::CMD_LIST8A, rcsp_pkg::CMD_LIST16A, rcsp_pkg::CMD_LIST8B,
			rcsp_pkg::CMD_LIST16B, rcsp_pkg::CMD_BURST8, rcsp_pkg::CMD_BURST16,
			rcsp_pkg::CMD_TARGET, rcsp_pkg::CMD_HWRESET,
			rcsp_pkg::CMD_WAIT8A, rcsp_pkg::CMD_WAIT16A,
			rcsp_pkg::CMD_WAIT8B, rcsp_pkg::CMD_WAIT16B: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void push_item(logic [1:0] o, logic [7:0] b, bit typed, bit has_res,
			result_t r);
		stim_t s;
		s.op = o;
		s.b = b;
		s.typed = typed;
		s.has_res = has_res;
		s.res = r;
		stim_q.push_back(s);
	endfunction

	function automatic void push_rand(logic [1:0] o, logic [7:0] b);
		push_item(o, b, 1'b0, 1'b0, '0);
	endfunction

	// operand byte, now and then preceded by a pause in the middle of the command
	function automatic void push_operand(logic [7:0] b);
		if ($urandom_range(0, 24) == 0)
			push_rand(rcsp_pkg::OP_PAUSE, 8'($urandom));
		push_rand(rcsp_pkg::OP_BYTE, b);
	endfunction

	// sometimes end the stream right after a command byte
	function automatic bit cut_short();
		if ($urandom_range(0, 29) != 0)
			return 1'b0;
		push_rand(rcsp_pkg::OP_END, 8'($urandom));
		return 1'b1;
	endfunction

	function automatic logic [7:0] pick_address();
		if ($urandom_range(0, 11) == 0)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(0, 127));
	endfunction

	// up to two items the halted parser drops, then a stop to bring it back
	function automatic void push_recovery();
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 2))
				0: push_rand(rcsp_pkg::OP_BYTE, 8'($urandom));
				1: push_rand(rcsp_pkg::OP_PAUSE, 8'($urandom));
				default: push_rand(rcsp_pkg::OP_END, 8'($urandom));
			endcase
		end
		push_rand(rcsp_pkg::OP_STOP, 8'($urandom));
	endfunction

	function automatic void add_random_command();
		int pick;
		int count;
		logic [7:0] head;
		logic [7:0] addr;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			push_rand(rcsp_pkg::OP_BYTE,
				($urandom_range(0, 1) != 0) ? rcsp_pkg::CMD_NOOP : rcsp_pkg::CMD_FLUSH);
		end else if (pick < 20) begin
			addr = pick_address();
			push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_WRITE);
			if (cut_short())
				return;
			push_operand(addr);
			if (addr[7])
				push_recovery();
			else
				push_operand(8'($urandom));
		end else if (pick < 35) begin
			case ($urandom_range(0, 3))
				0: head = rcsp_pkg::CMD_LIST8A;
				1: head = rcsp_pkg::CMD_LIST16A;
				2: head = rcsp_pkg::CMD_LIST8B;
				default: head = rcsp_pkg::CMD_LIST16B;
			endcase
			count = $urandom_range(0, 4);
			push_rand(rcsp_pkg::OP_BYTE, head);
			if (cut_short())
				return;
			push_operand(8'(count));
			if (head[0])
				push_operand(8'h00);
			repeat (count) begin
				push_operand(8'($urandom));
				push_operand(8'($urandom));
			end
		end else if (pick < 50) begin
			head = ($urandom_range(0, 1) != 0) ? rcsp_pkg::CMD_BURST8 : rcsp_pkg::CMD_BURST16;
			addr = pick_address();
			count = $urandom_range(0, 6);
			push_rand(rcsp_pkg::OP_BYTE, head);
			if (cut_short())
				return;
			push_operand(addr);
			if (addr[7]) begin
				push_recovery();
				return;
			end
			push_operand(8'(count));
			if (head == rcsp_pkg::CMD_BURST16)
				push_operand(8'h00);
			repeat (count)
				push_operand(8'($urandom));
		end else if (pick < 58) begin
			push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_TARGET);
			if (cut_short())
				return;
			push_operand(8'($urandom));
		end else if (pick < 63) begin
			push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_HWRESET);
		end else if (pick < 75) begin
			case ($urandom_range(0, 3))
				0: head = rcsp_pkg::CMD_WAIT8A;
				1: head = rcsp_pkg::CMD_WAIT16A;
				2: head = rcsp_pkg::CMD_WAIT8B;
				default: head = rcsp_pkg::CMD_WAIT16B;
			endcase
			push_rand(rcsp_pkg::OP_BYTE, head);
			if (cut_short())
				return;
			push_operand(8'($urandom));
			if (head[0])
				push_operand(8'($urandom));
		end else if (pick < 83) begin
			push_rand(rcsp_pkg::OP_PAUSE, 8'($urandom));
		end else if (pick < 88) begin
			do
				head = 8'($urandom);
			while (is_command(head));
			push_rand(rcsp_pkg::OP_BYTE, head);
			push_recovery();
		end else if (pick < 92) begin
			push_rand(rcsp_pkg::OP_STOP, 8'($urandom));
		end else if (pick < 96) begin
			push_rand(rcsp_pkg::OP_END, 8'($urandom));
		end else begin
			// raw noise, then a stop in case it halted the parser
			push_rand(2'($urandom_range(0, 3)), 8'($urandom));
			push_rand(rcsp_pkg::OP_STOP, 8'($urandom));
		end
	endfunction

	function automatic string fmt_result(result_t r);
		return $sformatf("kind %0d target %02h addr %02h data %02h ticks %0d first %0b last %0b",
			r.kind, r.target, r.addr, r.data, r.ticks, r.is_first, r.is_last);
	endfunction

	function automatic void log_failure(string what, result_t want, result_t got);
		failures++;
		if (failures <= REPORT_MAX)
			$display("%s: expected %s, got %s", what, fmt_result(want), fmt_result(got));
	endfunction

	// Build the stimulus, release reset, then wait for the scoreboard to drain.
	initial begin : main
		arst_n = 1'b0;
		clear_parser();
		halted = 1'b0;

		// Directed table: extremes, each kind of command, and the special cases.
		// noop and flush do nothing
		push_item(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_NOOP, 1'b1, 1'b0, '0);
		push_item(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_FLUSH, 1'b1, 1'b0, '0);
		// single write at the highest legal address, default target
		push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_WRITE);
		push_rand(rcsp_pkg::OP_BYTE, 8'h7f);
		push_item(rcsp_pkg::OP_BYTE, 8'hff, 1'b1, 1'b1,
			make_result(rcsp_pkg::KIND_WRITE, rcsp_pkg::TARGET_RESET, 8'h7f, 8'hff, '0, 1'b0));
		push_item(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_HWRESET, 1'b1, 1'b1,
			make_result(rcsp_pkg::KIND_HWRESET, '0, '0, '0, '0, 1'b0));
		// shortest and longest waits
		push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_WAIT8A);
		push_item(rcsp_pkg::OP_BYTE, 8'h00, 1'b1, 1'b1,
			make_result(rcsp_pkg::KIND_WAIT, '0, '0, '0, 17'd1, 1'b0));
		push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_WAIT16A);
		push_rand(rcsp_pkg::OP_BYTE, 8'hff);
		push_item(rcsp_pkg::OP_BYTE, 8'hff, 1'b1, 1'b1,
			make_result(rcsp_pkg::KIND_WAIT, '0, '0, '0, 17'h10000, 1'b0));
		// move to target zero
		push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_TARGET);
		push_item(rcsp_pkg::OP_BYTE, 8'h00, 1'b1, 1'b0, '0);
		// zero-length burst and zero-length list stay silent
		push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_BURST8);
		push_rand(rcsp_pkg::OP_BYTE, 8'h05);
		push_item(rcsp_pkg::OP_BYTE, 8'h00, 1'b1, 1'b0, '0);
		push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_LIST8A);
		push_item(rcsp_pkg::OP_BYTE, 8'h00, 1'b1, 1'b0, '0);
		// pause in the middle of a write, parsing resumes after the note-off run
		push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_WRITE);
		push_rand(rcsp_pkg::OP_PAUSE, 8'h00);
		push_rand(rcsp_pkg::OP_BYTE, 8'h00);
		push_rand(rcsp_pkg::OP_BYTE, 8'h00);
		// end of stream drops a partial list and restores target 3
		push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_LIST8B);
		push_item(rcsp_pkg::OP_END, 8'h00, 1'b1, 1'b0, '0);
		// bad burst address halts the parser until stop
		push_rand(rcsp_pkg::OP_BYTE, rcsp_pkg::CMD_BURST16);
		push_item(rcsp_pkg::OP_BYTE, 8'h80, 1'b1, 1'b1,
			make_result(rcsp_pkg::KIND_BAD_ADDR, rcsp_pkg::TARGET_RESET, 8'h80,
				rcsp_pkg::CMD_BURST16, '0, 1'b0));
		push_item(rcsp_pkg::OP_BYTE, 8'h55, 1'b1, 1'b0, '0);
		push_item(rcsp_pkg::OP_PAUSE, 8'h00, 1'b1, 1'b0, '0);
		push_item(rcsp_pkg::OP_END, 8'h00, 1'b1, 1'b0, '0);
		push_item(rcsp_pkg::OP_STOP, 8'h00, 1'b1, 1'b1,
			make_result(rcsp_pkg::KIND_HWRESET, '0, '0, '0, '0, 1'b0));
		// unknown command byte
		push_item(rcsp_pkg::OP_BYTE, 8'h01, 1'b1, 1'b1,
			make_result(rcsp_pkg::KIND_BAD_CMD, rcsp_pkg::TARGET_RESET, '0, 8'h01, '0, 1'b0));
		push_item(rcsp_pkg::OP_STOP, 8'hff, 1'b1, 1'b1,
			make_result(rcsp_pkg::KIND_HWRESET, '0, '0, '0, '0, 1'b0));

		while (stim_q.size() < TOTAL_ITEMS)
			add_random_command();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		wait (sender_done);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items (%0d pauses) and checked %0d results, %0d errors.",
			items_taken, pause_items, results_seen, error_results);
		$display("Mismatches and stray results: %0d.", failures);
		if (failures == 0)
			$display("PASS register_command_stream_parser_top");
		else
			$display("FAIL register_command_stream_parser_top");
		$finish;
	end

	// Offer items in order; hold each until taken, with random idle bursts.
	initial begin : sender
		int nxt;
		int gap;
		bit may_idle;
		in_valid = 1'b0;
		op = rcsp_pkg::OP_BYTE;
		stream_byte = '0;
		offer_idx = 0;
		nxt = 0;
		gap = 0;
		wait (arst_n === 1'b1);
		while (nxt < stim_q.size() || in_valid) begin
			@(posedge clk);
			if (in_valid && !in_ready)
				continue;
			may_idle = (nxt + QUIET_TAIL < stim_q.size()) && ((nxt / 50) % 3 != 2);
			if (nxt >= stim_q.size()) begin
				in_valid <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				in_valid <= 1'b0;
			end else if (may_idle && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(0, 10);
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				op <= stim_q[nxt].op;
				stream_byte <= stim_q[nxt].b;
				offer_idx <= nxt;
				nxt++;
			end
		end
		sender_done = 1'b1;
	end

	// Stall the result side in bursts, plus one long hold-off that backs up the input.
	initial begin : receiver
		int hold;
		bit long_done;
		out_ready = 1'b0;
		hold = 0;
		long_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (!long_done && items_taken >= LONG_HOLD_AT) begin
				long_done = 1'b1;
				hold = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (items_taken + QUIET_TAIL < stim_q.size() &&
					(items_taken / 40) % 3 != 1 && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Predict on every accepted item; check every accepted result against the oldest one owed.
	always @(posedge clk) begin : scoreboard
		stim_t   item;
		result_t want;
		result_t got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				item = stim_q[offer_idx];
				decode_item(item.op, item.b);
				if (item.typed) begin
					if (item.has_res) begin
						want = item.res;
						want.is_last = 1'b1;
						expected_results.push_back(want);
					end
				end else begin
					foreach (decoded_q[i])
						expected_results.push_back(decoded_q[i]);
				end
				if (item.op == rcsp_pkg::OP_PAUSE)
					pause_items++;
				items_taken <= items_taken + 1;
			end
			if (out_valid && out_ready) begin
				got.kind = kind;
				got.target = target;
				got.addr = reg_address;
				got.data = reg_data;
				got.ticks = wait_ticks;
				got.is_first = burst_first;
				got.is_last = run_last;
				results_seen++;
				if (kind == rcsp_pkg::KIND_BAD_CMD || kind == rcsp_pkg::KIND_BAD_ADDR)
					error_results++;
				if (expected_results.size() == 0) begin
					log_failure("result with nothing owed", '0, got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want)
						log_failure("result mismatch", want, got);
				end
			end
		end
	end

	// Hard stop if the run hangs.
	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results still owed.",
			cycle_count, expected_results.size());
		$display("FAIL register_command_stream_parser_top");
		$finish;
	end

endmodule
